/* rtl/core/pbrd_pkg.sv */
// Package for the PackBits row decoder: run command, position config,
// register indexes and constants. No dependencies.
package pbrd_pkg;

  localparam int unsigned QueueDepth = 4;

  localparam logic [7:0] NoopHeader  = 8'h80;
  localparam logic [8:0] RepeatBase  = 9'h101;

  typedef enum logic [1:0] {
    CfgRowBytes   = 2'd0,
    CfgRowTotal   = 2'd1,
    CfgPlaneTotal = 2'd2,
    CfgRleEnable  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PhHeader  = 3'b001,
    PhLiteral = 3'b010,
    PhRepeat  = 3'b100
  } phase_e;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] len;
    logic       done;
  } run_cmd_t;

  typedef struct packed {
    logic [15:0] row_bytes;
    logic [15:0] row_total;
    logic [1:0]  plane_total;
  } pos_cfg_t;

endpackage

/* rtl/core/pbrd_byte_if.sv */
// Input byte channel: valid/ready handshake with one data byte per beat.
// No dependencies.
interface pbrd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

/* rtl/core/pbrd_run_if.sv */
// Output run channel: valid/ready handshake with one decoded run per beat.
// No dependencies.
interface pbrd_run_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value;
  logic [7:0]  run_length;
  logic [15:0] column;
  logic [15:0] row;
  logic [1:0]  plane;
  logic        row_end;
  logic        last;

  modport source (output valid, output value, output run_length, output column,
                  output row, output plane, output row_end, output last,
                  input ready);
  modport sink   (input valid, input value, input run_length, input column,
                  input row, input plane, input row_end, input last,
                  output ready);
endinterface

/* rtl/core/pbrd_queue.sv */
// Small flop FIFO of run commands between header parser and position tracker.
// Depends on pbrd_pkg.
module pbrd_queue import pbrd_pkg::*; #(
  parameter int unsigned Depth = QueueDepth
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  run_cmd_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output run_cmd_t data_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  run_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue pop while empty");

endmodule

/* rtl/core/pbrd_front.sv */
// Header parser: takes input bytes, tracks PackBits phase and counts,
// and queues one run command per data byte. Depends on pbrd_pkg, pbrd_byte_if.
module pbrd_front import pbrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rle_en_i,
  pbrd_byte_if.sink   in_i,
  output logic        push_o,
  output run_cmd_t    cmd_o,
  input  logic        full_i
);

  phase_e     phase_q, phase_d;
  logic [7:0] lit_left_q, lit_left_d;
  logic [7:0] rep_cnt_q, rep_cnt_d;
  logic [7:0] lit_dec;
  logic       beat;
  logic       emit;

  assign in_i.ready = !full_i;
  assign beat       = in_i.valid && in_i.ready;
  assign lit_dec    = lit_left_q - 8'd1;
  assign push_o     = beat && emit;

  always_comb begin
    phase_d      = phase_q;
    lit_left_d   = lit_left_q;
    rep_cnt_d    = rep_cnt_q;
    emit         = 1'b0;
    cmd_o.value  = in_i.byte_in;
    cmd_o.len    = 8'd1;
    cmd_o.done   = 1'b1;
    if (!rle_en_i) begin
      phase_d    = PhHeader;
      lit_left_d = '0;
      rep_cnt_d  = '0;
      emit       = 1'b1;
    end else begin
      unique case (phase_q)
        PhLiteral: begin
          lit_left_d = lit_dec;
          emit       = 1'b1;
          cmd_o.done = (lit_dec == '0);
          if (lit_dec == '0) begin
            phase_d = PhHeader;
          end
        end
        PhRepeat: begin
          phase_d   = PhHeader;
          emit      = 1'b1;
          cmd_o.len = rep_cnt_q;
        end
        PhHeader: begin
          if (in_i.byte_in < NoopHeader) begin
            lit_left_d = in_i.byte_in + 8'd1;
            phase_d    = PhLiteral;
          end else if (in_i.byte_in > NoopHeader) begin
            rep_cnt_d = 8'(RepeatBase - {1'b0, in_i.byte_in});
            phase_d   = PhRepeat;
          end
        end
        default: begin
          phase_d = PhHeader;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhHeader;
      lit_left_q <= '0;
      rep_cnt_q  <= '0;
    end else if (beat) begin
      phase_q    <= phase_d;
      lit_left_q <= lit_left_d;
      rep_cnt_q  <= rep_cnt_d;
    end
  end

  a_lit_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhLiteral) |-> (lit_left_q != '0))
    else $error("literal phase with empty count");

endmodule

/* rtl/core/pbrd_back.sv */
// Position tracker: pops run commands, advances column/row/plane and holds
// the result in an output register. Depends on pbrd_pkg, pbrd_run_if.
module pbrd_back import pbrd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  pos_cfg_t    cfg_i,
  input  logic        empty_i,
  input  run_cmd_t    cmd_i,
  output logic        pop_o,
  pbrd_run_if.source  out_o
);

  logic [16:0] col_q, col_d;
  logic [15:0] row_q, row_d;
  logic [1:0]  plane_q, plane_d;

  logic        valid_q;
  logic [7:0]  value_q, len_q;
  logic [15:0] ocol_q, orow_q;
  logic [1:0]  oplane_q;
  logic        row_end_q, last_q;

  logic [16:0] col_sum;
  logic [15:0] row_inc, rows;
  logic [1:0]  plane_inc, planes;
  logic        end_d, last_d;

  assign pop_o     = !empty_i && (!valid_q || out_o.ready);
  assign col_sum   = col_q + {9'd0, cmd_i.len};
  assign row_inc   = row_q + 16'd1;
  assign plane_inc = plane_q + 2'd1;
  assign rows      = (cfg_i.row_total == '0) ? 16'd1 : cfg_i.row_total;
  assign planes    = (cfg_i.plane_total == '0) ? 2'd1 : cfg_i.plane_total;

  always_comb begin
    col_d   = col_sum;
    row_d   = row_q;
    plane_d = plane_q;
    end_d   = 1'b0;
    last_d  = 1'b0;
    if (cmd_i.done && (col_sum >= {1'b0, cfg_i.row_bytes})) begin
      end_d = 1'b1;
      col_d = '0;
      row_d = row_inc;
      if (row_inc >= rows) begin
        row_d   = '0;
        plane_d = plane_inc;
        if (plane_inc >= planes) begin
          plane_d = '0;
          last_d  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      plane_q <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        col_q   <= col_d;
        row_q   <= row_d;
        plane_q <= plane_d;
        valid_q <= 1'b1;
      end else if (out_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q   <= cmd_i.value;
      len_q     <= cmd_i.len;
      ocol_q    <= col_q[15:0];
      orow_q    <= row_q;
      oplane_q  <= plane_q;
      row_end_q <= end_d;
      last_q    <= last_d;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.value      = value_q;
  assign out_o.run_length = len_q;
  assign out_o.column     = ocol_q;
  assign out_o.row        = orow_q;
  assign out_o.plane      = oplane_q;
  assign out_o.row_end    = row_end_q;
  assign out_o.last       = last_q;

  a_last_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> row_end_q)
    else $error("last without row end");

  a_row_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && end_d) |=> (col_q == '0))
    else $error("column not cleared at row end");

endmodule

/* rtl/core/packbits_row_decoder.sv */
// PackBits row decoder, top level. Takes one byte per beat and returns one run
// beat per data byte (raw bytes, literal bytes, repeat values); header bytes
// give no beat. While the output side takes every run beat, the sustained
// rate is one byte per cycle, set by the column/row/plane update in the back
// end; an accepted data byte is written into the queue and then into the
// output register before it shows up as a result. A QueueDepth-entry queue
// decouples the header parser from the output side.
// Configuration writes take effect at the next edge and belong to idle times.
module packbits_row_decoder import pbrd_pkg::*; #(
  parameter int unsigned QueueDepth_p = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  pbrd_byte_if.sink   in_i,
  pbrd_run_if.source  out_o
);

  pos_cfg_t cfg_q;
  logic     rle_en_q;
  logic     push, pop, full, empty;
  run_cmd_t push_cmd, pop_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_bytes   <= 16'd1;
      cfg_q.row_total   <= 16'd1;
      cfg_q.plane_total <= 2'd1;
      rle_en_q          <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgRowBytes:   cfg_q.row_bytes   <= cfg_data_i;
        CfgRowTotal:   cfg_q.row_total   <= cfg_data_i;
        CfgPlaneTotal: cfg_q.plane_total <= cfg_data_i[1:0];
        CfgRleEnable:  rle_en_q          <= cfg_data_i[0];
      endcase
    end
  end

  pbrd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rle_en_i (rle_en_q),
    .in_i     (in_i),
    .push_o   (push),
    .cmd_o    (push_cmd),
    .full_i   (full)
  );

  pbrd_queue #(
    .Depth (QueueDepth_p)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  pbrd_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* bench/pbrd_run_check_pkg.sv */
// Run predictor for the PackBits row decoder bench: follows the decode state
// and holds the runs still due at the output. Depends on pbrd_pkg.
package pbrd_run_check_pkg;
  import pbrd_pkg::*;

  typedef struct packed {
    logic [7:0]  value;
    logic [7:0]  run_length;
    logic [15:0] column;
    logic [15:0] row;
    logic [1:0]  plane;
    logic        row_end;
    logic        last;
  } run_t;

  class run_predictor;
    logic [15:0] row_bytes;
    logic [15:0] row_total;
    logic [1:0]  plane_total;
    logic        rle_on;

    phase_e      ph;
    logic [7:0]  lit_left;
    logic [7:0]  rep_len;
    logic [16:0] col;
    logic [15:0] row;
    logic [1:0]  plane;

    run_t        runs_due[$];
    int          mismatches;

    function new();
      row_bytes   = 16'd1;
      row_total   = 16'd1;
      plane_total = 2'd1;
      rle_on      = 1'b0;
      ph          = PhHeader;
      lit_left    = 8'd0;
      rep_len     = 8'd0;
      col         = 17'd0;
      row         = 16'd0;
      plane       = 2'd0;
      mismatches  = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [15:0] data);
      case (idx)
        CfgRowBytes:   row_bytes = data;
        CfgRowTotal:   row_total = data;
        CfgPlaneTotal: plane_total = data[1:0];
        CfgRleEnable:  rle_on = data[0];
        default: ;
      endcase
    endfunction

    function void push_run(logic [7:0] val, logic [7:0] len, bit done);
      run_t        r;
      logic [15:0] rows;
      logic [1:0]  planes;
      rows   = (row_total == 16'd0) ? 16'd1 : row_total;
      planes = (plane_total == 2'd0) ? 2'd1 : plane_total;
      r.value      = val;
      r.run_length = len;
      r.column     = col[15:0];
      r.row        = row;
      r.plane      = plane;
      r.row_end    = 1'b0;
      r.last       = 1'b0;
      col = col + 17'(len);
      if (done && col >= {1'b0, row_bytes}) begin
        r.row_end = 1'b1;
        col = 17'd0;
        row = row + 16'd1;
        if (row >= rows) begin
          row = 16'd0;
          plane = plane + 2'd1;
          if (plane >= planes) begin
            plane = 2'd0;
            r.last = 1'b1;
          end
        end
      end
      runs_due.push_back(r);
    endfunction

    function void take_byte(logic [7:0] b);
      logic [8:0] rep;
      if (!rle_on) begin
        ph       = PhHeader;
        lit_left = 8'd0;
        rep_len  = 8'd0;
        push_run(b, 8'd1, 1'b1);
      end else begin
        case (ph)
          PhLiteral: begin
            lit_left = lit_left - 8'd1;
            if (lit_left == 8'd0) ph = PhHeader;
            push_run(b, 8'd1, lit_left == 8'd0);
          end
          PhRepeat: begin
            ph = PhHeader;
            push_run(b, rep_len, 1'b1);
          end
          default: begin
            if (b < NoopHeader) begin
              lit_left = b + 8'd1;
              ph = PhLiteral;
            end else if (b > NoopHeader) begin
              rep = RepeatBase - {1'b0, b};
              rep_len = rep[7:0];
              ph = PhRepeat;
            end
          end
        endcase
      end
    endfunction

    function string describe(run_t r);
      return $sformatf("val %h len %0d col %0d row %0d plane %0d end %b last %b",
                       r.value, r.run_length, r.column, r.row, r.plane, r.row_end, r.last);
    endfunction

    function void match_run(run_t got);
      run_t want;
      bit   bad;
      if (runs_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("run beat with nothing due: %s", describe(got));
        return;
      end
      want = runs_due.pop_front();
      bad = (got.value !== want.value) || (got.run_length !== want.run_length) ||
            (got.column !== want.column) || (got.row !== want.row) ||
            (got.plane !== want.plane) || (got.row_end !== want.row_end) ||
            (got.last !== want.last);
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("run mismatch at %0t", $time);
          $display("  expected %s", describe(want));
          $display("  actual   %s", describe(got));
        end
      end
    endfunction

    function int due();
      return runs_due.size();
    endfunction
  endclass

endpackage

/* bench/tb_top.sv */
// Top-level bench for packbits_row_decoder: drives byte beats and register
// writes, predicts each run beat and checks it. Depends on pbrd_pkg,
// pbrd_byte_if, pbrd_run_if and pbrd_run_check_pkg.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import pbrd_pkg::*;
  import pbrd_run_check_pkg::*;

  localparam int HoldCycles  = 180;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 10;
  localparam int RandomBytes = 770;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we;
  cfg_idx_e    cfg_idx;
  logic [15:0] cfg_data;

  pbrd_byte_if in_if ();
  pbrd_run_if  out_if ();

  run_predictor pred = new();

  int stall_cnt = 0;
  int beats_out = 0;
  bit tx_fast, rx_fast;
  int tx_left = 0;
  int rx_left = 0;

  packbits_row_decoder dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int draw_gap(inout bit fast, inout int left);
    if (left == 0) begin
      fast = ($urandom_range(0, 3) == 0);
      left = $urandom_range(8, 40);
    end
    left--;
    return fast ? 0 : $urandom_range(0, 13);
  endfunction

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = draw_gap(tx_fast, tx_left);
    repeat (gap) begin
      @(negedge clk_i);
      in_if.valid = 1'b0;
    end
    @(negedge clk_i);
    in_if.valid   = 1'b1;
    in_if.byte_in = b;
    do @(posedge clk_i); while (!in_if.ready);
    pred.take_byte(b);
  endtask

  task automatic send_random(int n);
    repeat (n) send_byte(8'($urandom));
  endtask

  // one PackBits packet, a no-op, a stray byte, or a raw byte
  task automatic send_packet(output int cnt);
    int r, n;
    r = $urandom_range(0, 99);
    if (!pred.rle_on || r < 8) begin
      send_byte(8'($urandom));
      cnt = 1;
    end else if (r < 13) begin
      send_byte(NoopHeader);
      cnt = 1;
    end else if (r < 55) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
      send_byte(8'(n));
      send_random(n + 1);
      cnt = n + 2;
    end else begin
      send_byte(8'($urandom_range(129, 255)));
      send_byte(8'($urandom));
      cnt = 2;
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (pred.due() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    pred.write_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic configure(logic [15:0] rb, logic [15:0] rt, logic [1:0] pt, logic rle);
    wait_idle();
    write_reg(CfgRowBytes, rb);
    write_reg(CfgRowTotal, rt);
    write_reg(CfgPlaneTotal, {14'd0, pt});
    write_reg(CfgRleEnable, {15'd0, rle});
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // run beat sink; holds off twice so the run queue backs up into the input
  initial begin
    run_t got;
    int   gap;
    @(posedge rst_ni);
    forever begin
      if (beats_out == 100 || beats_out == 400) begin
        @(negedge clk_i);
        out_if.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      gap = draw_gap(rx_fast, rx_left);
      repeat (gap) begin
        @(negedge clk_i);
        out_if.ready = 1'b0;
      end
      @(negedge clk_i);
      out_if.ready = 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      got.value      = out_if.value;
      got.run_length = out_if.run_length;
      got.column     = out_if.column;
      got.row        = out_if.row;
      got.plane      = out_if.plane;
      got.row_end    = out_if.row_end;
      got.last       = out_if.last;
      pred.match_run(got);
      beats_out++;
    end
  end

  initial begin
    logic [7:0]  raw_seq[8] = '{8'h00, 8'hFF, 8'h80, 8'h7F, 8'h81, 8'h55, 8'hAA, 8'h01};
    logic [7:0]  rle_seq[16] = '{8'h80, 8'h00, 8'h11, 8'hFF, 8'h22, 8'h81, 8'h33,
                                 8'h05, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                                 8'h02, 8'h40};
    logic [15:0] rb, rt;
    int          left, n, cnt, r;

    rst_ni        = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CfgRowBytes;
    cfg_data      = 16'd0;
    in_if.valid   = 1'b0;
    in_if.byte_in = 8'd0;
    out_if.ready  = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // raw bytes across rows and from the first plane into the second
    configure(16'd3, 16'd2, 2'd3, 1'b0);
    foreach (raw_seq[i]) send_byte(raw_seq[i]);

    // no-op, short literal, repeats, literal crossing the row width;
    // ends inside a literal so the switch to raw must clear it
    configure(16'd4, 16'd2, 2'd1, 1'b1);
    foreach (rle_seq[i]) send_byte(rle_seq[i]);

    configure(16'd0, 16'd0, 2'd0, 1'b0);
    send_random(6);

    left = RandomBytes;
    while (left > 0) begin
      r  = $urandom_range(0, 9);
      rb = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd1 :
           16'($urandom_range(2, 24));
      r  = $urandom_range(0, 9);
      rt = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : 16'($urandom_range(1, 5));
      configure(rb, rt, 2'($urandom_range(0, 3)), $urandom_range(0, 3) != 0);
      n = $urandom_range(60, 140);
      while (n > 0 && left > 0) begin
        send_packet(cnt);
        n    -= cnt;
        left -= cnt;
      end
    end

    wait_idle();
    if (pred.mismatches == 0 && pred.due() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pbrd_pkg.sv
rtl/core/pbrd_byte_if.sv
rtl/core/pbrd_run_if.sv
rtl/core/pbrd_queue.sv
rtl/core/pbrd_front.sv
rtl/core/pbrd_back.sv
rtl/core/packbits_row_decoder.sv
bench/pbrd_run_check_pkg.sv
bench/tb_top.sv
